[src/sscp_pkg.sv]
// shared constants for the segment pair closest point pipeline
package sscp_pkg;

  localparam int LIMIT_BITS  = 32;
  localparam int LIMIT_RESET = 43;
  localparam int MUL_LAT     = 4;
  localparam int DIV_EXTRA   = 3;

endpackage

[src/sscp_delay.sv]
// enabled shift line that carries a word a fixed number of stages
module sscp_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] line_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      line_r[0] <= din;
      for (int k = 1; k < DEPTH; k++) begin
        line_r[k] <= line_r[k-1];
      end
    end
  end

  assign dout = line_r[DEPTH-1];

endmodule

[src/sscp_mul.sv]
// pipelined signed multiplier built from four half-width partial products
module sscp_mul #(
  parameter int WIDTH = 52
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [WIDTH-1:0]   op_a,
  input  logic signed [WIDTH-1:0]   op_b,
  output logic signed [2*WIDTH-1:0] prod
);

  localparam int H = (WIDTH + 1) / 2;

  logic [2*H-1:0] ma_r, mb_r;
  logic           neg1_r, neg2_r, neg3_r;
  logic [2*H-1:0] p00_r, p01_r, p10_r, p11_r;
  logic [4*H-1:0] mag_r;
  logic [4*H-1:0] mag_nxt;
  logic [2*WIDTH-1:0] prod_r;
  logic [WIDTH-1:0] abs_a, abs_b;

  always_comb begin
    abs_a = op_a[WIDTH-1] ? WIDTH'(-op_a) : WIDTH'(op_a);
    abs_b = op_b[WIDTH-1] ? WIDTH'(-op_b) : WIDTH'(op_b);
    mag_nxt = (4*H)'(p00_r) + ((4*H)'(p01_r) << H) + ((4*H)'(p10_r) << H)
            + ((4*H)'(p11_r) << (2*H));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma_r   <= (2*H)'(abs_a);
      mb_r   <= (2*H)'(abs_b);
      neg1_r <= op_a[WIDTH-1] ^ op_b[WIDTH-1];
      p00_r  <= (2*H)'(ma_r[H-1:0]) * (2*H)'(mb_r[H-1:0]);
      p01_r  <= (2*H)'(ma_r[H-1:0]) * (2*H)'(mb_r[2*H-1:H]);
      p10_r  <= (2*H)'(ma_r[2*H-1:H]) * (2*H)'(mb_r[H-1:0]);
      p11_r  <= (2*H)'(ma_r[2*H-1:H]) * (2*H)'(mb_r[2*H-1:H]);
      neg2_r <= neg1_r;
      mag_r  <= mag_nxt;
      neg3_r <= neg2_r;
      prod_r <= neg3_r ? (2*WIDTH)'(-mag_r) : (2*WIDTH)'(mag_r);
    end
  end

  assign prod = $signed(prod_r);

endmodule

[src/sscp_div.sv]
// pipelined restoring divider giving a clamped rounded Q1 fraction num/den
module sscp_div #(
  parameter int WIDTH = 106,
  parameter int FRAC  = 16
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [WIDTH-1:0] num,
  input  logic signed [WIDTH-1:0] den,
  output logic        [FRAC:0]    quo
);

  localparam int UW = WIDTH - 1;
  localparam int NS = FRAC + 1;

  logic [UW-1:0] rem_r  [NS+1];
  logic [UW-1:0] den_r  [NS+1];
  logic [FRAC:0] q_r    [NS+1];
  logic          zero_r [NS+1];
  logic          one_r  [NS+1];
  logic [FRAC:0] quo_r;
  logic [FRAC+1:0] rnd;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= num[UW-1:0];
      den_r[0]  <= den[UW-1:0];
      q_r[0]    <= '0;
      zero_r[0] <= (den <= 0) || (num <= 0);
      one_r[0]  <= num >= den;
    end
  end

  for (genvar k = 1; k <= NS; k++) begin : g_step
    logic [UW:0] sh;
    logic        ge;
    always_comb begin
      sh = {rem_r[k-1], 1'b0};
      ge = sh >= {1'b0, den_r[k-1]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? UW'(sh - {1'b0, den_r[k-1]}) : UW'(sh);
        den_r[k]  <= den_r[k-1];
        q_r[k]    <= {q_r[k-1][FRAC-1:0], ge};
        zero_r[k] <= zero_r[k-1];
        one_r[k]  <= one_r[k-1];
      end
    end
  end

  assign rnd = ((FRAC+2)'(q_r[NS]) + (FRAC+2)'(1)) >> 1;

  always_ff @(posedge clk) begin
    if (en) begin
      if (zero_r[NS]) begin
        quo_r <= '0;
      end else if (one_r[NS]) begin
        quo_r <= (FRAC+1)'(1) << FRAC;
      end else begin
        quo_r <= rnd[FRAC:0];
      end
    end
  end

  assign quo = quo_r;

endmodule

[src/segment_segment_closest_points.sv]
// top level: closest points and parameters of two 3d segments, fully pipelined
//
// in_* carries one segment pair per beat (signed Q8.16 start and end points);
// out_* carries the clamped parameters (Q1.16) and both closest points.
// both channels are valid/ready. one pair enters every cycle unless the
// output is stalled; the pipeline holds two chained restoring dividers of
// FRACTION_BITS+3 stages each plus the dot products, four-stage wide
// multipliers and the final interpolation.
// cfg_wr_en/cfg_wr_data load the squared-length degeneracy limit (Q0.32),
// which resets to 43; write it only while the pipeline is empty.
// synchronous active-low reset clears all stage valid bits and reloads the limit.
// when the receiver stalls the whole pipeline holds, in_ready drops and
// nothing is lost or repeated.
module segment_segment_closest_points #(
  parameter int FRACTION_BITS = 16,
  parameter int COORD_BITS    = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [sscp_pkg::LIMIT_BITS-1:0] cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_seg1_start_x,
  input  logic signed [COORD_BITS-1:0] in_seg1_start_y,
  input  logic signed [COORD_BITS-1:0] in_seg1_start_z,
  input  logic signed [COORD_BITS-1:0] in_seg1_end_x,
  input  logic signed [COORD_BITS-1:0] in_seg1_end_y,
  input  logic signed [COORD_BITS-1:0] in_seg1_end_z,
  input  logic signed [COORD_BITS-1:0] in_seg2_start_x,
  input  logic signed [COORD_BITS-1:0] in_seg2_start_y,
  input  logic signed [COORD_BITS-1:0] in_seg2_start_z,
  input  logic signed [COORD_BITS-1:0] in_seg2_end_x,
  input  logic signed [COORD_BITS-1:0] in_seg2_end_y,
  input  logic signed [COORD_BITS-1:0] in_seg2_end_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [FRACTION_BITS:0]       out_param_one,
  output logic [FRACTION_BITS:0]       out_param_two,
  output logic signed [COORD_BITS-1:0] out_near1_x,
  output logic signed [COORD_BITS-1:0] out_near1_y,
  output logic signed [COORD_BITS-1:0] out_near1_z,
  output logic signed [COORD_BITS-1:0] out_near2_x,
  output logic signed [COORD_BITS-1:0] out_near2_y,
  output logic signed [COORD_BITS-1:0] out_near2_z
);

  localparam int FB   = FRACTION_BITS;
  localparam int CW   = COORD_BITS;
  localparam int DW   = CW + 1;
  localparam int PRW  = 2 * DW;
  localparam int PW   = 2 * DW + 2;
  localparam int MW   = 2 * PW;
  localparam int NW   = MW + 1;
  localparam int LB   = sscp_pkg::LIMIT_BITS;
  localparam int ML   = sscp_pkg::MUL_LAT;
  localparam int LD   = FB + sscp_pkg::DIV_EXTRA;
  localparam int S1   = 5 + ML + LD;
  localparam int TS   = S1 + ML + 1;
  localparam int SEL  = TS + 1;
  localparam int D2   = SEL + LD;
  localparam int LAST = D2 + 3;
  localparam int LW   = DW + FB + 2;
  localparam logic [FB:0] ONE = (FB+1)'(1) << FB;

  logic en;
  logic [LAST:1] vld_r;
  logic [LB-1:0] limit_r;

  assign en       = !vld_r[LAST] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      limit_r <= LB'(sscp_pkg::LIMIT_RESET);
    end else begin
      if (cfg_wr_en) limit_r <= cfg_wr_data;
      if (en) vld_r <= {vld_r[LAST-1:1], in_valid};
    end
  end

  // stage 1: input beat
  logic [2:0][CW-1:0] p1_r, q1_r, p2_r, q2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      p1_r <= {in_seg1_start_z, in_seg1_start_y, in_seg1_start_x};
      q1_r <= {in_seg1_end_z, in_seg1_end_y, in_seg1_end_x};
      p2_r <= {in_seg2_start_z, in_seg2_start_y, in_seg2_start_x};
      q2_r <= {in_seg2_end_z, in_seg2_end_y, in_seg2_end_x};
    end
  end

  // stage 2: direction and offset vectors
  logic [2:0][DW-1:0] d1_r, d2_r, rr_r, d1_nxt, d2_nxt, rr_nxt;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d1_nxt[i] = DW'($signed(q1_r[i])) - DW'($signed(p1_r[i]));
      d2_nxt[i] = DW'($signed(q2_r[i])) - DW'($signed(p2_r[i]));
      rr_nxt[i] = DW'($signed(p1_r[i])) - DW'($signed(p2_r[i]));
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      d1_r <= d1_nxt;
      d2_r <= d2_nxt;
      rr_r <= rr_nxt;
    end
  end

  // stage 3: component products
  logic [2:0][PRW-1:0] aa_r, ee_r, ff_r, cc_r, bb_r;
  logic [2:0][PRW-1:0] aa_nxt, ee_nxt, ff_nxt, cc_nxt, bb_nxt;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      aa_nxt[i] = PRW'($signed(d1_r[i])) * PRW'($signed(d1_r[i]));
      ee_nxt[i] = PRW'($signed(d2_r[i])) * PRW'($signed(d2_r[i]));
      ff_nxt[i] = PRW'($signed(d2_r[i])) * PRW'($signed(rr_r[i]));
      cc_nxt[i] = PRW'($signed(d1_r[i])) * PRW'($signed(rr_r[i]));
      bb_nxt[i] = PRW'($signed(d1_r[i])) * PRW'($signed(d2_r[i]));
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      aa_r <= aa_nxt;
      ee_r <= ee_nxt;
      ff_r <= ff_nxt;
      cc_r <= cc_nxt;
      bb_r <= bb_nxt;
    end
  end

  // stage 4: dot products
  logic signed [PW-1:0] a_r, e_r, f_r, c_r, b_r;
  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= PW'($signed(aa_r[0])) + PW'($signed(aa_r[1])) + PW'($signed(aa_r[2]));
      e_r <= PW'($signed(ee_r[0])) + PW'($signed(ee_r[1])) + PW'($signed(ee_r[2]));
      f_r <= PW'($signed(ff_r[0])) + PW'($signed(ff_r[1])) + PW'($signed(ff_r[2]));
      c_r <= PW'($signed(cc_r[0])) + PW'($signed(cc_r[1])) + PW'($signed(cc_r[2]));
      b_r <= PW'($signed(bb_r[0])) + PW'($signed(bb_r[1])) + PW'($signed(bb_r[2]));
    end
  end

  // stage 5: degeneracy tests and side numerators
  logic signed [PW-1:0] negc_r, bmc_r;
  logic                 deg1_r, deg2_r;
  logic signed [PW-1:0] lim_ext;
  assign lim_ext = $signed({{(PW-LB){1'b0}}, limit_r});
  always_ff @(posedge clk) begin
    if (en) begin
      deg1_r <= a_r <= lim_ext;
      deg2_r <= e_r <= lim_ext;
      negc_r <= -c_r;
      bmc_r  <= b_r - c_r;
    end
  end

  // stages 5..8: wide products
  logic signed [MW-1:0] ae, bsq, bf, ce;
  sscp_mul #(.WIDTH(PW)) u_mul_ae (.clk, .en, .op_a(a_r), .op_b(e_r), .prod(ae));
  sscp_mul #(.WIDTH(PW)) u_mul_bb (.clk, .en, .op_a(b_r), .op_b(b_r), .prod(bsq));
  sscp_mul #(.WIDTH(PW)) u_mul_bf (.clk, .en, .op_a(b_r), .op_b(f_r), .prod(bf));
  sscp_mul #(.WIDTH(PW)) u_mul_ce (.clk, .en, .op_a(c_r), .op_b(e_r), .prod(ce));

  // stage 9: general case fraction
  logic signed [NW-1:0] denom_r, snum_r;
  always_ff @(posedge clk) begin
    if (en) begin
      denom_r <= NW'(ae) - NW'(bsq);
      snum_r  <= NW'(bf) - NW'(ce);
    end
  end

  logic [FB:0] s1;
  sscp_div #(.WIDTH(NW), .FRAC(FB)) u_div_s (
    .clk, .en, .num(snum_r), .den(denom_r), .quo(s1)
  );

  // t numerator b*s + f*2^fb
  logic [PW-1:0] b_d, f_d, e_d, f_q, e_q, a_q, negc_q, bmc_q;
  logic [1:0]    deg_q;
  logic [FB:0]   s1_q;
  sscp_delay #(.WIDTH(PW), .DEPTH(S1-4)) u_dly_b (.clk, .en, .din(b_r), .dout(b_d));
  sscp_delay #(.WIDTH(PW), .DEPTH(TS-5)) u_dly_f (.clk, .en, .din(f_r), .dout(f_d));
  sscp_delay #(.WIDTH(PW), .DEPTH(TS-5)) u_dly_e (.clk, .en, .din(e_r), .dout(e_d));
  sscp_delay #(.WIDTH(PW), .DEPTH(TS-4)) u_dly_fq (.clk, .en, .din(f_r), .dout(f_q));
  sscp_delay #(.WIDTH(PW), .DEPTH(TS-4)) u_dly_eq (.clk, .en, .din(e_r), .dout(e_q));
  sscp_delay #(.WIDTH(PW), .DEPTH(TS-4)) u_dly_aq (.clk, .en, .din(a_r), .dout(a_q));
  sscp_delay #(.WIDTH(PW), .DEPTH(TS-5)) u_dly_nc (.clk, .en, .din(negc_r), .dout(negc_q));
  sscp_delay #(.WIDTH(PW), .DEPTH(TS-5)) u_dly_bc (.clk, .en, .din(bmc_r), .dout(bmc_q));
  sscp_delay #(.WIDTH(2), .DEPTH(TS-5)) u_dly_dg (
    .clk, .en, .din({deg1_r, deg2_r}), .dout(deg_q)
  );
  sscp_delay #(.WIDTH(FB+1), .DEPTH(TS-S1)) u_dly_s1 (.clk, .en, .din(s1), .dout(s1_q));

  logic signed [MW-1:0] bs;
  logic signed [PW-1:0] s1_ext;
  assign s1_ext = $signed({{(PW-FB-1){1'b0}}, s1});
  sscp_mul #(.WIDTH(PW)) u_mul_bs (
    .clk, .en, .op_a($signed(b_d)), .op_b(s1_ext), .prod(bs)
  );

  logic signed [NW-1:0] tnum_r, tden_r;
  always_ff @(posedge clk) begin
    if (en) begin
      tnum_r <= NW'(bs) + (NW'($signed(f_d)) <<< FB);
      tden_r <= NW'($signed(e_d)) <<< FB;
    end
  end

  // select stage: pick the second division and the fixed parameter
  logic signed [NW-1:0] num2_r, den2_r, num2_nxt, den2_nxt;
  logic                 to_t_r, to_t_nxt;
  logic [FB:0]          fix_r, fix_nxt;
  always_comb begin
    num2_nxt = '0;
    den2_nxt = '0;
    to_t_nxt = 1'b0;
    fix_nxt  = '0;
    if (deg_q[1] && deg_q[0]) begin
      num2_nxt = '0;
    end else if (deg_q[1]) begin
      num2_nxt = NW'($signed(f_q));
      den2_nxt = NW'($signed(e_q));
      to_t_nxt = 1'b1;
    end else if (deg_q[0] || tnum_r < 0) begin
      num2_nxt = NW'($signed(negc_q));
      den2_nxt = NW'($signed(a_q));
    end else if (tnum_r > tden_r) begin
      num2_nxt = NW'($signed(bmc_q));
      den2_nxt = NW'($signed(a_q));
      fix_nxt  = ONE;
    end else begin
      num2_nxt = tnum_r;
      den2_nxt = tden_r;
      to_t_nxt = 1'b1;
      fix_nxt  = s1_q;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      num2_r <= num2_nxt;
      den2_r <= den2_nxt;
      to_t_r <= to_t_nxt;
      fix_r  <= fix_nxt;
    end
  end

  logic [FB:0] q2, fix_d;
  logic        to_t_d;
  sscp_div #(.WIDTH(NW), .FRAC(FB)) u_div_2 (
    .clk, .en, .num(num2_r), .den(den2_r), .quo(q2)
  );
  sscp_delay #(.WIDTH(FB+2), .DEPTH(LD)) u_dly_fix (
    .clk, .en, .din({to_t_r, fix_r}), .dout({to_t_d, fix_d})
  );

  // final parameters
  logic [FB:0] s_r, t_r, s_o_r, t_o_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= to_t_d ? fix_d : q2;
      t_r <= to_t_d ? q2 : fix_d;
    end
  end

  // interpolation
  logic [3*DW-1:0] d1_d, d2_d;
  logic [3*CW-1:0] p1_d, p2_d;
  sscp_delay #(.WIDTH(3*DW), .DEPTH(D2-1)) u_dly_d1 (.clk, .en, .din(d1_r), .dout(d1_d));
  sscp_delay #(.WIDTH(3*DW), .DEPTH(D2-1)) u_dly_d2 (.clk, .en, .din(d2_r), .dout(d2_d));
  sscp_delay #(.WIDTH(3*CW), .DEPTH(D2+1)) u_dly_p1 (.clk, .en, .din(p1_r), .dout(p1_d));
  sscp_delay #(.WIDTH(3*CW), .DEPTH(D2+1)) u_dly_p2 (.clk, .en, .din(p2_r), .dout(p2_d));

  logic [2:0][LW-1:0] lp1_r, lp2_r, lp1_nxt, lp2_nxt;
  logic [2:0][CW-1:0] n1_r, n2_r, n1_nxt, n2_nxt;
  logic [2:0][LW-1:0] sum1, sum2;
  logic signed [LW-1:0] s_ext, t_ext, half;
  assign s_ext = $signed({{(LW-FB-1){1'b0}}, s_r});
  assign t_ext = $signed({{(LW-FB-1){1'b0}}, t_r});
  assign half  = LW'(1) <<< (FB - 1);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lp1_nxt[i] = LW'($signed(d1_d[i*DW +: DW])) * s_ext + half;
      lp2_nxt[i] = LW'($signed(d2_d[i*DW +: DW])) * t_ext + half;
      sum1[i] = LW'($signed(p1_d[i*CW +: CW])) + ($signed(lp1_r[i]) >>> FB);
      sum2[i] = LW'($signed(p2_d[i*CW +: CW])) + ($signed(lp2_r[i]) >>> FB);
      n1_nxt[i] = sum1[i][CW-1:0];
      n2_nxt[i] = sum2[i][CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lp1_r <= lp1_nxt;
      lp2_r <= lp2_nxt;
      s_o_r <= s_r;
      t_o_r <= t_r;
      n1_r  <= n1_nxt;
      n2_r  <= n2_nxt;
    end
  end

  // output beat
  logic [FB:0] s_out_r, t_out_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s_out_r <= s_o_r;
      t_out_r <= t_o_r;
    end
  end

  assign out_valid     = vld_r[LAST];
  assign out_param_one = s_out_r;
  assign out_param_two = t_out_r;
  assign out_near1_x   = $signed(n1_r[0]);
  assign out_near1_y   = $signed(n1_r[1]);
  assign out_near1_z   = $signed(n1_r[2]);
  assign out_near2_x   = $signed(n2_r[0]);
  assign out_near2_y   = $signed(n2_r[1]);
  assign out_near2_z   = $signed(n2_r[2]);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_param_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_param_one <= ONE) && (out_param_two <= ONE))
    else $error("parameter above one");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (vld_r == $past(vld_r)))
    else $error("pipeline moved during stall");

endmodule
